// ===== rtl/core/sfc_pkg.sv =====
// shared types, constants and keypad decode for the stick frame conditioner
package sfc_pkg;

   localparam int SampleWidth = 10;
   localparam int ChanWidth   = 8;
   localparam int MarginWidth = 8;
   localparam int PeakWidth   = 10;
   localparam int SweepWidth  = 11;
   localparam int CntWidth    = SweepWidth + 1;
   localparam int NumLanes    = 4;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   // lane order: throttle, yaw, roll, pitch
   localparam int LaneThrottle = 0;
   localparam int LaneYaw      = 1;
   localparam int LaneRoll     = 2;
   localparam int LanePitch    = 3;

   // register indexes on the csr port
   localparam logic [1:0] CSR_DEADBAND   = 2'd0;
   localparam logic [1:0] CSR_BIND_PEAK  = 2'd1;
   localparam logic [1:0] CSR_BLINK_PEAK = 2'd2;

   localparam logic [MarginWidth-1:0] DEADBAND_RESET   = 8'd2;
   localparam logic [PeakWidth-1:0]   BIND_PEAK_RESET  = 10'd256;
   localparam logic [PeakWidth-1:0]   BLINK_PEAK_RESET = 10'd255;

   localparam logic [7:0] FLAG_BINDING = 8'hC0;
   localparam logic [7:0] FLAG_BLINK   = 8'h10;
   localparam logic [7:0] FLAG_CLEAR   = 8'h00;
   localparam logic [7:0] FLAG_LEFT    = 8'h80;
   localparam logic [7:0] FLAG_RIGHT   = 8'h40;
   localparam logic [7:0] FLAG_THIRD   = 8'h08;

   localparam logic [ChanWidth-1:0] CHAN_FULL  = 8'hFF;
   localparam logic [ChanWidth-1:0] CHAN_ZERO  = 8'h00;
   localparam logic [ChanWidth-1:0] MIRROR_MID = 8'h80;
   localparam logic [ChanWidth-1:0] MIRROR_TOP = 8'h7F;

   // keypad codes
   localparam logic [2:0] KEY_NONE  = 3'd0;
   localparam logic [2:0] KEY_ONE   = 3'd1;
   localparam logic [2:0] KEY_TWO   = 3'd2;
   localparam logic [2:0] KEY_THREE = 3'd3;
   localparam logic [2:0] KEY_FOUR  = 3'd4;
   localparam logic [2:0] KEY_FIVE  = 3'd5;
   localparam logic [2:0] KEY_ALL   = 3'd6;

   typedef logic [ChanWidth-1:0] chan_type;

   typedef struct packed {
      chan_type throttle;
      chan_type yaw;
      chan_type roll;
      chan_type pitch;
   } lanes_type;

   typedef struct packed {
      logic left;
      logic right;
      logic third;
   } buttons_type;

   typedef struct packed {
      chan_type   throttle;
      chan_type   yaw;
      chan_type   pitch;
      chan_type   roll;
      logic [7:0] flags;
      logic       changed;
   } frame_type;

   function automatic logic [2:0] ladder_code(input logic [SampleWidth-1:0] ks);
      logic [2:0] code;
      code = KEY_NONE;
      if (ks == 10'h3FF) begin
         code = KEY_ALL;
      end else if (ks >= 10'h09E && ks <= 10'h09F) begin
         code = KEY_ONE;
      end else if (ks >= 10'h12F && ks <= 10'h132) begin
         code = KEY_TWO;
      end else if (ks >= 10'h1C4 && ks <= 10'h1C9) begin
         code = KEY_THREE;
      end else if (ks >= 10'h263 && ks <= 10'h269) begin
         code = KEY_FOUR;
      end else if (ks >= 10'h319 && ks <= 10'h31F) begin
         code = KEY_FIVE;
      end
      return code;
   endfunction

   function automatic chan_type mirror(input chan_type v);
      return (v < MIRROR_MID) ? (MIRROR_TOP - v) : v;
   endfunction

endpackage

// ===== rtl/core/sfc_lane.sv =====
// one stick channel: scale down, deadband compare and held value
module sfc_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [sfc_pkg::SampleWidth-1:0]  sample,
   input  logic [sfc_pkg::MarginWidth-1:0]  margin,
   output sfc_pkg::chan_type                held_next,
   output logic                             changed
);
   import sfc_pkg::*;

   chan_type held_ff;
   chan_type held_in;
   chan_type scaled;
   chan_type diff;

   assign scaled = sample[SampleWidth-1:2];
   assign diff   = (scaled >= held_ff) ? (scaled - held_ff) : (held_ff - scaled);
   assign changed   = (diff > margin);
   assign held_next = changed ? scaled : held_ff;
   assign held_in   = advance ? held_next : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== rtl/core/sfc_merge.sv =====
// bind and blink sweep, flag byte and mirrored axes from the lane results
module sfc_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  sfc_pkg::lanes_type              held,
   input  logic [sfc_pkg::NumLanes-1:0]    lane_changed,
   input  sfc_pkg::buttons_type            buttons,
   input  logic [sfc_pkg::SampleWidth-1:0] ladder,
   input  logic [sfc_pkg::PeakWidth-1:0]   bind_peak,
   input  logic [sfc_pkg::PeakWidth-1:0]   blink_peak,
   output sfc_pkg::frame_type              frame
);
   import sfc_pkg::*;

   logic [SweepWidth-1:0] sweep_ff, sweep_in;
   logic                  down_ff, down_in;
   logic                  binding_ff, binding_in;
   logic [7:0]            flag_ff, flag_in;
   chan_type              yaw_ff, yaw_in;
   chan_type              pitch_ff, pitch_in;
   chan_type              roll_ff, roll_in;

   always_comb begin
      logic signed [CntWidth-1:0] cnt;
      logic signed [CntWidth-1:0] bind_lim;
      logic signed [CntWidth-1:0] blink_lim;
      logic [7:0]                 flag;
      logic                       down;
      logic                       bind_on;
      logic [SweepWidth-1:0]      sweep;
      chan_type                   yaw, pitch, roll;

      bind_lim  = $signed({2'b00, bind_peak});
      blink_lim = $signed({2'b00, blink_peak});
      cnt   = $signed({1'b0, sweep_ff}) + (down_ff ? -12'sd1 : 12'sd1);
      flag  = flag_ff;
      down  = down_ff;
      bind_on = binding_ff;
      sweep = sweep_ff;
      yaw   = yaw_ff;
      pitch = pitch_ff;
      roll  = roll_ff;

      if (binding_ff) begin
         flag  = FLAG_BINDING;
         sweep = cnt[CntWidth-1] ? '0 : cnt[SweepWidth-1:0];
         if (!down) begin
            if (cnt > bind_lim) down = 1'b1;
         end else if (cnt[CntWidth-1]) begin
            down  = 1'b0;
            sweep = '0;
            bind_on = 1'b0;
            flag  = FLAG_CLEAR;
         end
         // throttle check runs after the counter check, same tick
         if (!down) begin
            if (held.throttle == CHAN_FULL) down = 1'b1;
         end else if (held.throttle == CHAN_ZERO) begin
            down  = 1'b0;
            sweep = '0;
            bind_on = 1'b0;
            flag  = FLAG_CLEAR;
         end
      end else begin
         yaw   = mirror(held.yaw);
         roll  = mirror(held.roll);
         pitch = mirror(held.pitch);
         if (!down) begin
            if (cnt > blink_lim) begin
               down = 1'b1;
               cnt  = blink_lim;
               flag = FLAG_BLINK;
            end
         end else if (cnt[CntWidth-1]) begin
            down = 1'b0;
            cnt  = '0;
            flag = FLAG_CLEAR;
         end
         sweep = cnt[SweepWidth-1:0];
      end

      if (buttons.left)  flag = flag | FLAG_LEFT;
      if (buttons.right) flag = flag | FLAG_RIGHT;
      if (buttons.third) flag = flag | FLAG_THIRD;
      flag = flag | {5'b0, ladder_code(ladder)};

      sweep_in   = sweep;
      down_in    = down;
      binding_in = bind_on;
      flag_in    = flag;
      yaw_in     = yaw;
      pitch_in   = pitch;
      roll_in    = roll;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff   <= '0;
         down_ff    <= 1'b0;
         binding_ff <= 1'b1;
         flag_ff    <= '0;
         yaw_ff     <= '0;
         pitch_ff   <= '0;
         roll_ff    <= '0;
      end else if (advance) begin
         sweep_ff   <= sweep_in;
         down_ff    <= down_in;
         binding_ff <= binding_in;
         flag_ff    <= flag_in;
         yaw_ff     <= yaw_in;
         pitch_ff   <= pitch_in;
         roll_ff    <= roll_in;
      end
   end

   assign frame.throttle = held.throttle;
   assign frame.yaw      = yaw_in;
   assign frame.pitch    = pitch_in;
   assign frame.roll     = roll_in;
   assign frame.flags    = flag_in;
   assign frame.changed  = |lane_changed;

`ifndef SYNTHESIS
   a_bind_never_restarts: assert property (@(posedge clock) disable iff (reset)
      !$rose(binding_ff))
      else $error("binding restarted without reset");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      sweep_ff <= 11'd1024)
      else $error("sweep counter out of range");

   a_bind_ends_at_zero: assert property (@(posedge clock) disable iff (reset)
      $fell(binding_ff) |-> sweep_ff == '0)
      else $error("sweep counter not cleared at end of binding");

   a_bind_flags: assert property (@(posedge clock) disable iff (reset)
      advance && binding_ff && binding_in |=> flag_ff[7:6] == 2'b11)
      else $error("bind flags missing while binding");
`endif

endmodule

// ===== rtl/core/stick_frame_conditioner.sv =====
// stick frame conditioner top: csr block, four channel lanes, merge and output stage
//
//   channel   direction   handshake                         beat
//   req_      in          req_valid / req_ready             four samples, buttons, ladder
//   rsp_      out         rsp_valid / rsp_ready             one conditioned frame
//   csr_      in/out      psel, penable, pwrite, pready     32-bit register access
//
// one beat is accepted per cycle while req_ready is high; its frame enters the output
// register in the next cycle; lane compare, sweep and flag update are combinational.
// a stalled frame blocks the next beat only while it is still not taken.
// reset is synchronous: held channels, sweep and axes clear, binding starts,
// registers return to their defaults.
module stick_frame_conditioner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sfc_pkg::SampleWidth-1:0]     req_sample_throttle,
   input  logic [sfc_pkg::SampleWidth-1:0]     req_sample_yaw,
   input  logic [sfc_pkg::SampleWidth-1:0]     req_sample_roll,
   input  logic [sfc_pkg::SampleWidth-1:0]     req_sample_pitch,
   input  logic                                req_left_pressed,
   input  logic                                req_right_pressed,
   input  logic                                req_third_pressed,
   input  logic [sfc_pkg::SampleWidth-1:0]     req_ladder_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sfc_pkg::ChanWidth-1:0]       rsp_throttle_out,
   output logic [sfc_pkg::ChanWidth-1:0]       rsp_yaw_out,
   output logic [sfc_pkg::ChanWidth-1:0]       rsp_pitch_out,
   output logic [sfc_pkg::ChanWidth-1:0]       rsp_roll_out,
   output logic [7:0]                          rsp_flag_byte,
   output logic                                rsp_any_changed,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sfc_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [sfc_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [sfc_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import sfc_pkg::*;

   logic [MarginWidth-1:0] deadband_ff, deadband_in;
   logic [PeakWidth-1:0]   bind_peak_ff, bind_peak_in;
   logic [PeakWidth-1:0]   blink_peak_ff, blink_peak_in;
   logic                   csr_write;
   logic [1:0]             csr_index;

   logic                   advance;
   logic                   out_valid_ff, out_valid_in;
   frame_type              out_ff, out_in;
   frame_type              frame;
   lanes_type              held;
   logic [NumLanes-1:0]    lane_changed;
   buttons_type            buttons;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      deadband_in   = deadband_ff;
      bind_peak_in  = bind_peak_ff;
      blink_peak_in = blink_peak_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DEADBAND:   deadband_in   = csr_pwdata[MarginWidth-1:0];
            CSR_BIND_PEAK:  bind_peak_in  = csr_pwdata[PeakWidth-1:0];
            CSR_BLINK_PEAK: blink_peak_in = csr_pwdata[PeakWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DEADBAND:   csr_prdata = {{(CsrDataWidth-MarginWidth){1'b0}}, deadband_ff};
         CSR_BIND_PEAK:  csr_prdata = {{(CsrDataWidth-PeakWidth){1'b0}}, bind_peak_ff};
         CSR_BLINK_PEAK: csr_prdata = {{(CsrDataWidth-PeakWidth){1'b0}}, blink_peak_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff   <= DEADBAND_RESET;
         bind_peak_ff  <= BIND_PEAK_RESET;
         blink_peak_ff <= BLINK_PEAK_RESET;
      end else begin
         deadband_ff   <= deadband_in;
         bind_peak_ff  <= bind_peak_in;
         blink_peak_ff <= blink_peak_in;
      end
   end

   // input beat goes in whenever the output register is free or draining
   assign req_ready = !out_valid_ff || rsp_ready;
   assign advance   = req_valid && req_ready;

   sfc_lane u_lane_throttle (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .sample    (req_sample_throttle),
      .margin    (deadband_ff),
      .held_next (held.throttle),
      .changed   (lane_changed[LaneThrottle])
   );

   sfc_lane u_lane_yaw (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .sample    (req_sample_yaw),
      .margin    (deadband_ff),
      .held_next (held.yaw),
      .changed   (lane_changed[LaneYaw])
   );

   sfc_lane u_lane_roll (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .sample    (req_sample_roll),
      .margin    (deadband_ff),
      .held_next (held.roll),
      .changed   (lane_changed[LaneRoll])
   );

   sfc_lane u_lane_pitch (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .sample    (req_sample_pitch),
      .margin    (deadband_ff),
      .held_next (held.pitch),
      .changed   (lane_changed[LanePitch])
   );

   assign buttons.left  = req_left_pressed;
   assign buttons.right = req_right_pressed;
   assign buttons.third = req_third_pressed;

   sfc_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .held         (held),
      .lane_changed (lane_changed),
      .buttons      (buttons),
      .ladder       (req_ladder_sample),
      .bind_peak    (bind_peak_ff),
      .blink_peak   (blink_peak_ff),
      .frame        (frame)
   );

   // output register
   assign out_in       = advance ? frame : out_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_throttle_out = out_ff.throttle;
   assign rsp_yaw_out      = out_ff.yaw;
   assign rsp_pitch_out    = out_ff.pitch;
   assign rsp_roll_out     = out_ff.roll;
   assign rsp_flag_byte    = out_ff.flags;
   assign rsp_any_changed  = out_ff.changed;

`ifndef SYNTHESIS
   a_accept_gives_frame: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("accepted beat produced no frame");

   a_frame_taken_or_replaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !advance |=> !rsp_valid)
      else $error("frame repeated after being taken");

   a_csr_write_lands: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == CSR_DEADBAND |=>
         deadband_ff == $past(csr_pwdata[MarginWidth-1:0]))
      else $error("deadband write lost");
`endif

endmodule
